/* rtl/core/i2a_pkg.sv */
package i2a_pkg;

  // conversion codes
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_LHEX = 3'd2;
  localparam logic [2:0] CONV_UHEX = 3'd3;
  localparam logic [2:0] CONV_PTR  = 3'd4;

  // reciprocal of ten, exact for 32-bit operands with a shift of 35
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  // a 32-bit operand has at most ten decimal digits
  localparam int DIGITS_MAX  = 10;
  localparam int DIGIT_IDX_W = $clog2(DIGITS_MAX);

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  // control from the sequencer to the shared digit unit
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic hex;
  } unit_ctrl_t;

  // result of one digit step
  typedef struct packed {
    logic [3:0] digit;
    logic       final_digit;
  } unit_status_t;

  // digit value to ascii, upper or lower case letters
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      if (d < 4'd10) begin
        digit_char = CHAR_ZERO + {4'd0, d};
      end else begin
        base = upper ? CHAR_UP_A : CHAR_LOW_A;
        digit_char = base + {4'd0, d} - 8'd10;
      end
    end
  endfunction

endpackage

/* rtl/core/i2a_if.sv */
// request channel: operand and conversion controls
interface i2a_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [2:0]  conversion;
  logic [4:0]  pad_width;
  logic        zero_pad;

  modport source (output valid, value, conversion, pad_width, zero_pad, input ready);
  modport sink   (input valid, value, conversion, pad_width, zero_pad, output ready);
endinterface

// character channel: one ascii character per transfer
interface i2a_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

/* rtl/core/i2a_digit_unit.sv */
module i2a_digit_unit import i2a_pkg::*; (
  input  logic         clk,
  input  unit_ctrl_t   ctrl,
  input  logic [31:0]  value,
  output unit_status_t status
);

  logic [31:0] work;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] tenq;
  logic [3:0]  rem;

  // quotient by shift for hex, by reciprocal product for decimal
  always_comb begin
    if (ctrl.hex) begin
      quot = {4'd0, work[31:4]};
    end else begin
      quot = {3'd0, prod[63:RECIP10_SHIFT]};
    end
    tenq = (quot << 3) + (quot << 1);
    if (ctrl.hex) begin
      rem = work[3:0];
    end else begin
      rem = work[3:0] - tenq[3:0];
    end
  end

  assign status.digit       = rem;
  assign status.final_digit = (quot == 32'd0);

  // working value and registered product
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= value;
    end else if (ctrl.div) begin
      work <= quot;
    end
    if (ctrl.mul) begin
      prod <= work * RECIP10;
    end
  end

endmodule

/* rtl/core/integer_to_ascii_formatter.sv */
// channel   dir   payload                                   transfer
// request   in    value, conversion, pad_width, zero_pad    valid && ready
// text      out   character, last                           valid && ready
//
// an item is accepted while idle, then each digit takes a multiply state and a
// quotient and remainder state in the shared digit unit, at most ten digits;
// the characters then go out one per cycle while text is not stalled, and the
// pad state passes to the digit state without a character
// request.ready is high only while idle; rst is synchronous and clears control
// text stalls hold the sequencer in its emit state; the character register
// lets a new request be taken while the final character waits
module integer_to_ascii_formatter import i2a_pkg::*; #(
  parameter int MAX_WIDTH      = 31,
  parameter int POINTER_DIGITS = 8
) (
  input logic        clk,
  input logic        rst,
  i2a_req_if.sink    request,
  i2a_char_if.source text
);

  localparam int PAD_MAX = (MAX_WIDTH > POINTER_DIGITS) ? MAX_WIDTH : POINTER_DIGITS;
  localparam int WW      = $clog2(PAD_MAX + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PRE1 = 3'd3;
  localparam logic [2:0] S_PRE2 = 3'd4;
  localparam logic [2:0] S_PAD  = 3'd5;
  localparam logic [2:0] S_DIG  = 3'd6;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic                   neg;
  logic                   ptr;
  logic                   upper;
  logic                   hex;
  logic                   pad_zero;
  logic [WW-1:0]          width;
  logic [WW-1:0]          pad_left;
  logic [DIGIT_IDX_W-1:0] dig_idx;
  logic [3:0]             digits [DIGITS_MAX];

  logic                   out_valid;
  logic [7:0]             out_char;
  logic                   out_last;

  logic                   accept;
  logic                   conv_ok;
  logic                   in_neg;
  logic [31:0]            magnitude;
  logic                   emit_go;
  logic                   emit;
  logic [7:0]             emit_char;
  logic                   emit_last;
  logic [WW-1:0]          target;
  logic [WW-1:0]          count_new;
  unit_ctrl_t             ctrl;
  unit_status_t           status;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign conv_ok       = (request.conversion == CONV_SDEC) || (request.conversion == CONV_UDEC)
                      || (request.conversion == CONV_LHEX) || (request.conversion == CONV_UHEX)
                      || (request.conversion == CONV_PTR);
  assign in_neg        = (request.conversion == CONV_SDEC) && request.value[31];
  assign magnitude     = in_neg ? (32'd0 - request.value) : request.value;
  assign emit_go       = !out_valid || text.ready;

  assign target    = ptr ? WW'(POINTER_DIGITS) : width;
  assign count_new = WW'(dig_idx) + WW'(1);

  // shared digit unit
  always_comb begin
    ctrl.load = accept;
    ctrl.mul  = (state == S_MUL);
    ctrl.div  = (state == S_DIV);
    ctrl.hex  = hex;
  end

  i2a_digit_unit u_digit (
    .clk    (clk),
    .ctrl   (ctrl),
    .value  (magnitude),
    .status (status)
  );

  // sequencer and character choice
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_char  = CHAR_ZERO;
    emit_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && conv_ok) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.final_digit) begin
          state_next = (neg || ptr) ? S_PRE1 : S_PAD;
        end else begin
          state_next = S_MUL;
        end
      end
      S_PRE1: begin
        if (emit_go) begin
          emit       = 1'b1;
          emit_char  = ptr ? CHAR_ZERO : CHAR_MINUS;
          state_next = ptr ? S_PRE2 : S_PAD;
        end
      end
      S_PRE2: begin
        if (emit_go) begin
          emit       = 1'b1;
          emit_char  = CHAR_LOW_X;
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (pad_left == '0) begin
          state_next = S_DIG;
        end else if (emit_go) begin
          emit      = 1'b1;
          emit_char = pad_zero ? CHAR_ZERO : CHAR_SPACE;
        end
      end
      S_DIG: begin
        if (emit_go) begin
          emit      = 1'b1;
          emit_char = digit_char(digits[dig_idx], upper);
          emit_last = (dig_idx == '0);
          if (dig_idx == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item fields, digit buffer, counters and character register
  always_ff @(posedge clk) begin
    if (accept) begin
      neg      <= in_neg;
      ptr      <= (request.conversion == CONV_PTR);
      upper    <= (request.conversion == CONV_UHEX);
      hex      <= (request.conversion == CONV_LHEX) || (request.conversion == CONV_UHEX)
               || (request.conversion == CONV_PTR);
      pad_zero <= request.zero_pad || (request.conversion == CONV_PTR);
      width    <= (int'(request.pad_width) > MAX_WIDTH) ? WW'(MAX_WIDTH)
                                                        : WW'(request.pad_width);
      dig_idx  <= '0;
    end
    if (state == S_MUL) begin
      digits[dig_idx] <= status.digit;
    end
    if (state == S_DIV) begin
      digits[dig_idx] <= status.digit;
      if (status.final_digit) begin
        pad_left <= (target > count_new) ? (target - count_new) : '0;
      end else begin
        dig_idx <= dig_idx + DIGIT_IDX_W'(1);
      end
    end
    if (state == S_PAD && emit) begin
      pad_left <= pad_left - WW'(1);
    end
    if (state == S_DIG && emit && dig_idx != '0) begin
      dig_idx <= dig_idx - DIGIT_IDX_W'(1);
    end
    if (emit) begin
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  // the final digit leaves as a marked character
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIG && emit_go && dig_idx == '0) |=> (text.valid && text.last))
    else $error("final digit not marked last");

  // digit buffer index stays inside the buffer while dividing
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (int'(dig_idx) < DIGITS_MAX))
    else $error("digit index beyond buffer");

  // the x of the prefix only appears for pointers
  a_prefix_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRE2) |-> ptr)
    else $error("hex prefix outside pointer conversion");

  // no character is marked last before the digits
  a_last_digits: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |-> (state == S_DIG))
    else $error("last marker outside digit phase");

endmodule

/* bench/integer_to_ascii_formatter_checker.sv */
`timescale 1ns / 1ps

// watches both channels, predicts the text of every accepted request and
// compares each character transfer against the oldest prediction
module integer_to_ascii_formatter_checker import i2a_pkg::*; #(
  parameter int MAX_WIDTH      = 31,
  parameter int POINTER_DIGITS = 8
) (
  input  logic clk,
  input  logic rst,
  i2a_req_if   request,
  i2a_char_if  text,
  output int   pending,
  output int   fail_count,
  output int   characters_checked
);

  localparam int LINE_MAX  = 32;
  localparam int PRINT_MAX = 100;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  text_beat_t expected_text[$];
  int         reported;

  // printf-style rendering of one request into the expected characters
  function automatic void predict_text(input logic [31:0] value, input logic [2:0] conv,
                                       input logic [4:0] pad_width, input logic zero_pad);
    logic [7:0]  line_chars [LINE_MAX];
    logic [7:0]  digit_chars [LINE_MAX];
    logic [31:0] magnitude;
    logic [31:0] radix;
    logic [3:0]  digit;
    logic        upper;
    logic        pad_zero;
    logic        numeric;
    int          n;
    int          count;
    int          width;
    begin
      n         = 0;
      count     = 0;
      numeric   = 1'b1;
      upper     = 1'b0;
      radix     = 32'd10;
      magnitude = value;
      pad_zero  = zero_pad;
      width     = (int'(pad_width) > MAX_WIDTH) ? MAX_WIDTH : int'(pad_width);
      case (conv)
        CONV_SDEC: begin
          // sign first, then the magnitude; the most negative value wraps to itself
          if (value[31]) begin
            line_chars[n] = CHAR_MINUS;
            n++;
            magnitude = 32'd0 - value;
          end
        end
        CONV_UDEC: ;
        CONV_LHEX: radix = 32'd16;
        CONV_UHEX: begin
          radix = 32'd16;
          upper = 1'b1;
        end
        CONV_PTR: begin
          // pointer ignores the requested padding
          line_chars[0] = CHAR_ZERO;
          line_chars[1] = CHAR_LOW_X;
          n        = 2;
          radix    = 32'd16;
          width    = POINTER_DIGITS;
          pad_zero = 1'b1;
        end
        default: numeric = 1'b0;
      endcase
      if (numeric) begin
        // digits least significant first; zero still gives one digit
        do begin
          digit = 4'(magnitude % radix);
          if (digit < 4'd10) begin
            digit_chars[count] = CHAR_ZERO + 8'(digit);
          end else begin
            digit_chars[count] = (upper ? CHAR_UP_A : CHAR_LOW_A) + 8'(digit) - 8'd10;
          end
          count++;
          magnitude = magnitude / radix;
        end while (magnitude != 32'd0 && count < LINE_MAX);
        for (int i = count; i < width; i++) begin
          if (n < LINE_MAX) begin
            line_chars[n] = pad_zero ? CHAR_ZERO : CHAR_SPACE;
            n++;
          end
        end
        for (int i = count - 1; i >= 0; i--) begin
          if (n < LINE_MAX) begin
            line_chars[n] = digit_chars[i];
            n++;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        expected_text.push_back('{character: line_chars[i], last: (i == n - 1)});
      end
    end
  endfunction

  initial begin
    pending            = 0;
    fail_count         = 0;
    characters_checked = 0;
    reported           = 0;
  end

  // compare character transfers, then record new requests
  always @(posedge clk) begin
    text_beat_t want;
    if (!rst) begin
      if (text.valid && text.ready) begin
        characters_checked++;
        if (expected_text.size() == 0) begin
          fail_count++;
          if (reported < PRINT_MAX) begin
            reported++;
            $error("unexpected character transfer: character %h last %b",
                   text.character, text.last);
          end
        end else begin
          want = expected_text.pop_front();
          if (text.character !== want.character) begin
            fail_count++;
            if (reported < PRINT_MAX) begin
              reported++;
              $error("character mismatch: expected %h, actual %h",
                     want.character, text.character);
            end
          end
          if (text.last !== want.last) begin
            fail_count++;
            if (reported < PRINT_MAX) begin
              reported++;
              $error("last mismatch: expected %b, actual %b", want.last, text.last);
            end
          end
        end
      end
      if (request.valid && request.ready) begin
        predict_text(request.value, request.conversion, request.pad_width, request.zero_pad);
      end
    end
    pending = expected_text.size();
  end

endmodule

/* bench/integer_to_ascii_formatter_tb.sv */
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import i2a_pkg::*;

  localparam int RANDOM_ITEMS  = 125;
  localparam int HOLD_AT       = 40;
  localparam int PAUSE_AT      = 100;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int IDLE_LIMIT    = 2000;

  localparam logic [2:0] CONV_FIRST_UNUSED = CONV_PTR + 3'd1;

  logic clk;
  logic rst;

  i2a_req_if  request_ch ();
  i2a_char_if text_ch ();

  int pending;
  int fail_count;
  int characters_checked;

  int burst_left;
  int requests_sent;
  int silent_requests;
  int long_hold_requests;
  int long_holds_done;
  int idle_cycles;

  integer_to_ascii_formatter u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .text    (text_ch)
  );

  integer_to_ascii_formatter_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .request            (request_ch),
    .text               (text_ch),
    .pending            (pending),
    .fail_count         (fail_count),
    .characters_checked (characters_checked)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one request, with a random gap between bursts
  task automatic offer_request(input logic [31:0] v, input logic [2:0] c,
                               input logic [4:0] w, input logic z);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        request_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    request_ch.valid      <= 1'b1;
    request_ch.value      <= v;
    request_ch.conversion <= c;
    request_ch.pad_width  <= w;
    request_ch.zero_pad   <= z;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    requests_sent++;
    if (c > CONV_PTR) silent_requests++;
  endtask

  // stop offering until every predicted character has come out
  task automatic await_all_text();
    request_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // request side: directed cases, then random traffic
  initial begin : stimulus
    int          counted;
    logic [31:0] v;
    logic [2:0]  c;
    logic [4:0]  w;
    logic        z;
    rst                   <= 1'b1;
    request_ch.valid      <= 1'b0;
    request_ch.value      <= '0;
    request_ch.conversion <= CONV_SDEC;
    request_ch.pad_width  <= '0;
    request_ch.zero_pad   <= 1'b0;
    burst_left         = 0;
    requests_sent      = 0;
    silent_requests    = 0;
    long_hold_requests = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero, extremes, sign handling and padding, in decimal, hex and pointer form
    offer_request(32'd0,          CONV_SDEC, 5'd0,  1'b0);
    offer_request(32'h7FFF_FFFF,  CONV_SDEC, 5'd0,  1'b0);
    offer_request(32'h8000_0000,  CONV_SDEC, 5'd0,  1'b1);
    offer_request(32'hFFFF_FFFF,  CONV_SDEC, 5'd5,  1'b1);
    offer_request(-32'sd42,       CONV_SDEC, 5'd31, 1'b0);
    offer_request(32'd123,        CONV_SDEC, 5'd31, 1'b1);
    offer_request(32'hFFFF_FFFF,  CONV_UDEC, 5'd0,  1'b0);
    offer_request(32'd0,          CONV_UDEC, 5'd31, 1'b0);
    offer_request(32'd7,          CONV_UDEC, 5'd3,  1'b0);
    offer_request(32'd1234567,    CONV_UDEC, 5'd1,  1'b1);
    offer_request(32'hDEAD_BEEF,  CONV_LHEX, 5'd0,  1'b0);
    offer_request(32'd0,          CONV_LHEX, 5'd31, 1'b1);
    offer_request(32'h0000_0ABC,  CONV_LHEX, 5'd8,  1'b0);
    offer_request(32'hCAFE_F00D,  CONV_UHEX, 5'd2,  1'b1);
    offer_request(32'h0000_0001,  CONV_UHEX, 5'd4,  1'b1);
    offer_request(32'hFFFF_FFFF,  CONV_UHEX, 5'd31, 1'b0);
    offer_request(32'd0,          CONV_PTR,  5'd0,  1'b0);
    offer_request(32'hFFFF_FFFF,  CONV_PTR,  5'd31, 1'b0);
    offer_request(32'h0000_12AB,  CONV_PTR,  5'd3,  1'b1);
    // unused conversion codes produce no text
    for (int k = 0; k < 3; k++) begin
      offer_request($urandom, CONV_FIRST_UNUSED + 3'(k), 5'($urandom_range(0, 31)), k[0]);
    end
    await_all_text();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // long receiver hold-off with the sender kept busy
      if (counted == HOLD_AT && long_hold_requests == 0) begin
        long_hold_requests++;
        burst_left = 8;
      end
      if (counted == PAUSE_AT) begin
        await_all_text();
      end
      if ($urandom_range(0, 19) == 0) begin
        c = CONV_FIRST_UNUSED + 3'($urandom_range(0, 2));
      end else begin
        c = 3'($urandom_range(CONV_SDEC, CONV_PTR));
      end
      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 20);
        1: v = 32'd0 - 32'($urandom_range(1, 1000));
        2: begin
          case ($urandom_range(0, 3))
            0: v = 32'd0;
            1: v = 32'h8000_0000;
            2: v = 32'h7FFF_FFFF;
            default: v = 32'hFFFF_FFFF;
          endcase
        end
        default: v = $urandom;
      endcase
      w = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 12)) : 5'($urandom_range(13, 31));
      z = 1'($urandom_range(0, 1));
      offer_request(v, c, w, z);
      if (c <= CONV_PTR) counted++;
    end
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d with unused codes) and %0d characters,",
             requests_sent, silent_requests, characters_checked);
    $display("with a long receiver hold-off and pauses for the text to drain");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // text side: stall patterns of its own, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int stall_len;
    long_holds_done = 0;
    text_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_requests != long_holds_done) begin
        long_holds_done++;
        text_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode      = $urandom_range(0, 2);
        span      = $urandom_range(8, 60);
        stall_len = $urandom_range(1, 15);
        for (int i = 0; i < span; i++) begin
          case (mode)
            0: text_ch.ready <= 1'b1;
            1: text_ch.ready <= 1'($urandom_range(0, 1));
            default: text_ch.ready <= (i >= stall_len);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

/* filelist.f */
rtl/core/i2a_pkg.sv
rtl/core/i2a_if.sv
rtl/core/i2a_digit_unit.sv
rtl/core/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_checker.sv
bench/integer_to_ascii_formatter_tb.sv
